// ----- src/ascalc_pkg.sv -----
// Shared types and constants for the ASCII two-operand calculator.
package ascalc_pkg;

  // Width of the result port
  localparam int unsigned OUT_W = 32;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FORMAT  = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Characters the parser looks for
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Operation handed from the parser to the execution unit
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_FMT,
    OP_UNK
  } op_t;

  localparam int unsigned OP_W = 3;

endpackage

// ----- src/ascalc_front.sv -----
// Byte parser: scans "%d%c%d" and emits one job per expression.
module ascalc_front import ascalc_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   char_in,
  input  logic         last,
  output logic         job_push,
  output logic [W-1:0] job_a,
  output logic [W-1:0] job_b,
  output logic         job_bneg,
  output op_t          job_op
);

  typedef enum logic [2:0] {
    PH_N1_WS,
    PH_N1_NUM,
    PH_N2_WS,
    PH_N2_NUM,
    PH_DONE,
    PH_FAIL
  } phase_t;

  phase_t       phase, phase_next;
  logic [W-1:0] first, first_next;
  logic [W-1:0] run, run_next;
  logic         neg, neg_next;
  logic         seen, seen_next;
  logic [7:0]   opb, opb_next;

  logic         is_dig, is_ws, is_sgn;
  logic [W-1:0] acc, fin;

  // Classify the byte and prepare the digit and sign updates
  assign is_dig = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_ws  = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign is_sgn = (char_in == CH_PLUS) || (char_in == CH_MINUS);
  assign acc    = (run << 3) + (run << 1) + W'(char_in[3:0]);
  assign fin    = neg ? (W'(0) - run) : run;

  // Advance the parse by one byte
  always_comb begin
    phase_next = phase;
    first_next = first;
    run_next   = run;
    neg_next   = neg;
    seen_next  = seen;
    opb_next   = opb;
    unique case (phase)
      PH_N1_WS, PH_N2_WS: begin
        if (is_ws) begin
          phase_next = phase;
        end else if (is_sgn || is_dig) begin
          if (is_sgn) begin
            neg_next = (char_in == CH_MINUS);
          end else begin
            run_next  = acc;
            seen_next = 1'b1;
          end
          phase_next = (phase == PH_N1_WS) ? PH_N1_NUM : PH_N2_NUM;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_N1_NUM: begin
        if (is_dig) begin
          run_next  = acc;
          seen_next = 1'b1;
        end else if (seen && (char_in != CH_NUL)) begin
          first_next = fin;
          opb_next   = char_in;
          run_next   = '0;
          neg_next   = 1'b0;
          seen_next  = 1'b0;
          phase_next = PH_N2_WS;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_N2_NUM: begin
        if (is_dig) begin
          run_next  = acc;
          seen_next = 1'b1;
        end else if (seen) begin
          run_next   = fin;
          neg_next   = 1'b0;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_FAIL;
    endcase
  end

  // Build the job from the state after this byte
  always_comb begin
    job_a    = first_next;
    job_b    = run_next;
    job_bneg = neg_next;
    if (((phase_next == PH_N2_NUM) && seen_next) || (phase_next == PH_DONE)) begin
      unique case (opb_next)
        CH_PLUS:  job_op = OP_ADD;
        CH_MINUS: job_op = OP_SUB;
        CH_STAR:  job_op = OP_MUL;
        CH_SLASH: job_op = OP_DIV;
        default:  job_op = OP_UNK;
      endcase
    end else begin
      job_op = OP_FMT;
    end
  end

  assign job_push = take && last;

  // Hold parse state; drop it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_N1_WS;
      first <= '0;
      run   <= '0;
      neg   <= 1'b0;
      seen  <= 1'b0;
      opb   <= '0;
    end else if (take) begin
      if (last) begin
        phase <= PH_N1_WS;
        first <= '0;
        run   <= '0;
        neg   <= 1'b0;
        seen  <= 1'b0;
        opb   <= '0;
      end else begin
        phase <= phase_next;
        first <= first_next;
        run   <= run_next;
        neg   <= neg_next;
        seen  <= seen_next;
        opb   <= opb_next;
      end
    end
  end

endmodule

// ----- src/ascalc_queue.sv -----
// Small register FIFO that carries parsed jobs to the execution unit.
module ascalc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             nonempty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rd_data  = slots[rd_ptr];

  // Store an incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/ascalc_back.sv -----
// Execution unit: add, subtract, shift-add multiply and restoring divide.
module ascalc_back import ascalc_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  logic [W-1:0]     job_a,
  input  logic [W-1:0]     job_b,
  input  logic             job_bneg,
  input  op_t              job_op,
  output logic             job_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] value,
  output logic [1:0]       status
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  state_t       state;
  op_t          op;
  logic [W-1:0] a, b, res, rem;
  logic         bneg, qneg;
  logic [1:0]   stat;
  logic [CNT_W-1:0] cnt;

  logic [W:0]     rem_sh, diff;
  logic           ge;
  logic [W-1:0]   abs_a, abs_b;
  logic [OUT_W-1:0] res_ext;
  logic           load_out;

  assign job_pop  = (state == S_IDLE) && job_valid;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  // Divider step and operand magnitudes
  assign rem_sh = {rem, res[W-1]};
  assign ge     = rem_sh >= {1'b0, b};
  assign diff   = rem_sh - {1'b0, b};
  assign abs_a  = a[W-1] ? (W'(0) - a) : a;
  assign abs_b  = b[W-1] ? (W'(0) - b) : b;

  // Fit the result to the output width: sign-extend a narrower result, truncate a wider one
  generate
    if (W >= OUT_W) begin : g_trunc
      assign res_ext = res[OUT_W-1:0];
    end else begin : g_sext
      assign res_ext = {{(OUT_W - W){res[W-1]}}, res};
    end
  endgenerate

  // Sequence one job at a time; hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            a     <= job_a;
            b     <= job_b;
            bneg  <= job_bneg;
            op    <= job_op;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          b     <= bneg ? (W'(0) - b) : b;
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (op)
            OP_ADD: begin
              res   <= a + b;
              stat  <= ST_OK;
              state <= S_DONE;
            end
            OP_SUB: begin
              res   <= a - b;
              stat  <= ST_OK;
              state <= S_DONE;
            end
            OP_MUL: begin
              res   <= '0;
              stat  <= ST_OK;
              cnt   <= CNT_W'(W);
              state <= S_MUL;
            end
            OP_DIV: begin
              if (b == '0) begin
                res   <= '0;
                stat  <= ST_DIVZERO;
                state <= S_DONE;
              end else begin
                res   <= abs_a;
                rem   <= '0;
                b     <= abs_b;
                qneg  <= a[W-1] ^ b[W-1];
                stat  <= ST_OK;
                cnt   <= CNT_W'(W);
                state <= S_DIV;
              end
            end
            OP_UNK: begin
              res   <= '0;
              stat  <= ST_UNKNOWN;
              state <= S_DONE;
            end
            default: begin
              res   <= '0;
              stat  <= ST_FORMAT;
              state <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          if (b[0]) begin
            res <= res + a;
          end
          a   <= a << 1;
          b   <= b >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
          res <= {res[W-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          res   <= qneg ? (W'(0) - res) : res;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            value  <= res_ext;
            status <= stat;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ascii_two_operand_calculator_top.sv -----
// Top level of the ASCII two-operand calculator.
//
// Input channel: one byte of an expression per item (char_in), with last set
// on the final byte. The expression is parsed like "%d%c%d": whitespace, an
// optional sign and decimal digits, one operator byte, then a second number.
// Output channel: one item per expression, value (32-bit signed) and status
// (0 ok, 1 format error, 2 divide by zero, 3 unknown operator; value 0 on error).
// Bytes are taken one per cycle while in_stall is low. The parser hands each
// finished expression to a QUEUE_DEPTH-entry job queue; the execution unit
// drains it one job at a time, through states PREP and EXEC to DONE, where the
// result is registered; * runs the shift-add multiplier and / the restoring
// divider (one bit per cycle) and then a FIX step. in_stall rises only while
// the job queue is full, so throughput is one byte per cycle as long as
// expressions average more bytes than the execution time of one job.
// A stalled result holds in the output register while execution continues
// with the next job. Reset (rst, synchronous) clears the parser, queue and
// execution control; in_stall is low in the cycle after reset.
module ascii_two_operand_calculator_top import ascalc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       char_in,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] value,
  output logic [1:0]       status
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned JOB_W = 2 * W + 1 + OP_W;

  logic             take;
  logic             job_push, job_bneg, q_full, q_nonempty, q_pop;
  logic [W-1:0]     job_a, job_b;
  op_t              job_op;
  logic [JOB_W-1:0] q_wr, q_rd;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  // Parse bytes into jobs
  ascalc_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .char_in  (char_in),
    .last     (last),
    .job_push (job_push),
    .job_a    (job_a),
    .job_b    (job_b),
    .job_bneg (job_bneg),
    .job_op   (job_op)
  );

  assign q_wr = {job_op, job_bneg, job_b, job_a};

  // Buffer jobs between parser and execution
  ascalc_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .wr_data  (q_wr),
    .pop      (q_pop),
    .rd_data  (q_rd),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // Execute jobs
  ascalc_back #(.W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job_a     (q_rd[W-1:0]),
    .job_b     (q_rd[2*W-1:W]),
    .job_bneg  (q_rd[2*W]),
    .job_op    (op_t'(q_rd[JOB_W-1:2*W+1])),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

endmodule

// ----- src/ascalc_checker.sv -----
// Port-level checker for the calculator, bound to the top level.
module ascalc_checker import ascalc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [7:0]       char_in,
  input logic             last,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] value,
  input logic [1:0]       status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("stalled result changed");

  // Any error reports a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> value == '0)
    else $error("error result with nonzero value");

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the job queue so input is taken at once
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind ascii_two_operand_calculator_top ascalc_checker u_ascalc_checker (.*);
